// File: rtl/pow_difficulty_retarget_macros.svh
// Assertion macros shared by the difficulty retarget RTL.
`ifndef POW_DIFFICULTY_RETARGET_MACROS_SVH
`define POW_DIFFICULTY_RETARGET_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property that is switched off while reset is asserted.
`define PDR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset.
`define PDR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDR_ASSERT(lbl, clk, rstn, prop, msg)
`define PDR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/pdr_pkg.sv
`timescale 1ns / 1ps
// Types, constants and arithmetic helpers of the difficulty retarget block.
package pdr_pkg;

    // Chain rules.
    localparam int unsigned TARGET_BITS = 256;
    localparam int unsigned INTERVAL    = 2016;
    localparam int unsigned TIMESPAN    = 14 * 24 * 60 * 60;
    localparam int unsigned SPAN_MIN    = TIMESPAN / 4;
    localparam int unsigned SPAN_MAX    = TIMESPAN * 4;
    localparam logic [31:0] LIMIT_RESET = 32'h1D00FFFF;

    // Field widths.
    localparam int MANT_W = 23;
    localparam int EXP_W  = 8;
    localparam int SPAN_W = $clog2(SPAN_MAX + 1);
    localparam int PROD_W = MANT_W + SPAN_W;
    localparam int SIZE_W = 12;

    // Division by the timespan: the power-of-two part is a shift, the odd part
    // is removed one 16-bit digit at a time with a reciprocal multiply.
    // The quotient keeps three bytes of fraction so that a mantissa as small
    // as one still yields three exact significant bytes.
    localparam int          TS_SHIFT  = 8;
    localparam int unsigned TS_ODD    = TIMESPAN >> TS_SHIFT;
    localparam int          PRESHIFT  = 24 - TS_SHIFT;
    localparam int          NUM_W     = PROD_W + PRESHIFT;
    localparam int          DIG_W     = 16;
    localparam int          NDIG      = (NUM_W + DIG_W - 1) / DIG_W;
    localparam int          NUMP_W    = NDIG * DIG_W;
    localparam int          REM_W     = $clog2(TS_ODD);
    localparam int          T_W       = REM_W + DIG_W;
    localparam int          DIV_K     = T_W + REM_W;
    localparam logic [63:0] DIV_RECIP = ((64'd1 << DIV_K) + 64'(TS_ODD) - 64'd1) / 64'(TS_ODD);
    localparam int          RECIP_W   = $clog2(DIV_RECIP + 64'd1);
    localparam int          MULT_W    = T_W + RECIP_W;

    // Scaled quotient and normalized number form.
    localparam int Q_W    = 56;
    localparam int QBYTES = Q_W / 8;
    localparam int NB_W   = $clog2(QBYTES + 1);
    localparam int LEN_W  = 9;

    // Result queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Trailing zero count of a constant.
    function automatic int unsigned ctz32(input logic [31:0] v);
        int unsigned n;
        n = 0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) n = i;
        end
        return n;
    endfunction

    // Inverse of an odd constant modulo 2^32 by Newton iteration.
    function automatic logic [31:0] inv32(input logic [31:0] o);
        logic [31:0] x;
        x = o;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - o * x);
        end
        return x;
    endfunction

    // Interval boundary test: low bits zero and odd part divisible by multiply.
    localparam int unsigned INT_SHIFT   = ctz32(INTERVAL);
    localparam logic [31:0] INT_ODD     = 32'(INTERVAL >> INT_SHIFT);
    localparam logic [31:0] INT_INV     = inv32(INT_ODD);
    localparam logic [31:0] INT_LIM     = 32'hFFFFFFFF / INT_ODD;
    localparam logic [31:0] INT_LOWMASK = (32'd1 << INT_SHIFT) - 32'd1;

    // How the back end forms a result.
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_LIMIT = 2'd1,
        MODE_CALC  = 2'd2
    } pdr_mode_t;

    // One classified item in the queue.
    typedef struct packed {
        pdr_mode_t          mode;
        logic               retargeted;
        logic               bad;
        logic [31:0]        word;
        logic [PROD_W-1:0]  prod;
        logic [EXP_W-1:0]   expo;
    } pdr_item_t;

    // Side information that rides along the divider.
    typedef struct packed {
        pdr_mode_t          mode;
        logic               retargeted;
        logic               bad;
        logic [31:0]        word;
        logic [EXP_W-1:0]   expo;
    } pdr_bpay_t;

    // Queue status seen by both ends.
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [QCNT_W-1:0]  count;
    } pdr_qstat_t;

    // A value as byte length and left-justified top bytes.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [Q_W-1:0]   win;
    } pdr_num_t;

    // Bit length of a mantissa.
    function automatic logic [4:0] bitlen23(input logic [MANT_W-1:0] m);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (m[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    // Value x * 256^b brought into normalized form.
    function automatic pdr_num_t norm_num(input logic [Q_W-1:0] x, input logic [LEN_W-1:0] b);
        pdr_num_t   n;
        logic [NB_W-1:0] nb;
        nb = '0;
        for (int i = 0; i < QBYTES; i++) begin
            if (x[8*i +: 8] != 8'd0) nb = NB_W'(i + 1);
        end
        n.win = x << (8 * (QBYTES - int'(nb)));
        n.len = (nb == '0) ? '0 : LEN_W'(nb) + b;
        return n;
    endfunction

    // Decoded limit word, with bits at or above the target width dropped.
    function automatic pdr_num_t limit_num(input logic [31:0] lim);
        logic [7:0]        ls;
        logic [MANT_W-1:0] lm;
        logic [Q_W-1:0]    x;
        logic [LEN_W-1:0]  b;
        int                avail;
        ls = lim[31:24];
        lm = lim[MANT_W-1:0];
        avail = 0;
        if (ls <= 8'd3) begin
            x = Q_W'(lm >> (8 * (3 - int'(ls))));
            b = '0;
        end else begin
            b = LEN_W'(ls - 8'd3);
            avail = int'(TARGET_BITS) - 8 * int'(ls - 8'd3);
            if (avail <= 0) begin
                x = '0;
            end else if (avail < MANT_W) begin
                x = Q_W'(lm & ((MANT_W'(1) << avail) - MANT_W'(1)));
            end else begin
                x = Q_W'(lm);
            end
        end
        return norm_num(x, b);
    endfunction

    // Magnitude compare of two normalized values.
    function automatic logic num_gt(input pdr_num_t a, input pdr_num_t b);
        return (a.len > b.len) || ((a.len == b.len) && (a.win > b.win));
    endfunction

    // Standard compact encoding.
    function automatic logic [31:0] encode_num(input pdr_num_t n);
        logic [23:0] c;
        logic [7:0]  sz;
        c  = n.win[Q_W-1 -: 24];
        sz = n.len[7:0];
        if (c[23]) begin
            c  = c >> 8;
            sz = sz + 8'd1;
        end
        return {sz, c};
    endfunction

endpackage

// File: rtl/pdr_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, decodes the target, clamps the span and classifies.
module pdr_front import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_last,
    input  logic [30:0] s_last_height,
    input  logic [31:0] s_last_target,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_window_start_time,
    input  pdr_qstat_t  q_stat,
    output logic        push,
    output pdr_item_t   push_item
);

    logic               en;
    logic [31:0]        x_c;
    logic [MANT_W-1:0]  m_c;
    logic [7:0]         sz_c;
    logic               over_c;
    logic               bad_c;
    logic [MANT_W-1:0]  mant_c;
    logic [EXP_W-1:0]   expo_c;
    logic signed [32:0] d_c;
    logic [SPAN_W-1:0]  span_c;
    logic               boundary_c;

    logic               a_valid_reg;
    logic               a_has_last_reg;
    logic [31:0]        a_target_reg;
    logic               a_bad_reg;
    logic [MANT_W-1:0]  a_mant_reg;
    logic [EXP_W-1:0]   a_expo_reg;
    logic [SPAN_W-1:0]  a_span_reg;
    logic [31:0]        a_y_reg;
    logic               a_lowzero_reg;

    logic               b_valid_reg;
    logic               b_has_last_reg;
    logic [31:0]        b_target_reg;
    logic               b_bad_reg;
    logic [EXP_W-1:0]   b_expo_reg;
    logic [PROD_W-1:0]  b_prod_reg;
    logic [31:0]        b_mod_reg;
    logic               b_lowzero_reg;

    // The front stalls as a whole only when the queue cannot take its last item.
    assign en      = !(b_valid_reg && q_stat.full);
    assign s_ready = en;
    assign push    = b_valid_reg && !q_stat.full;

    // Decode of the compact word and the sign and size checks.
    assign x_c    = {1'b0, s_last_height} + 32'd1;
    assign m_c    = s_last_target[MANT_W-1:0];
    assign sz_c   = s_last_target[31:24];
    assign over_c = (sz_c > 8'd3) &&
                    (({7'd0, bitlen23(m_c)} + {1'b0, sz_c - 8'd3, 3'b000}) > SIZE_W'(TARGET_BITS));
    assign bad_c  = (m_c != '0) && (s_last_target[23] || over_c);
    assign mant_c = (sz_c <= 8'd3) ? (m_c >> (8 * (3 - int'(sz_c)))) : m_c;
    assign expo_c = (sz_c <= 8'd3) ? '0 : (sz_c - 8'd3);

    // Signed window span, clamped to a quarter and four times the timespan.
    assign d_c = $signed({1'b0, s_last_time}) - $signed({1'b0, s_window_start_time});
    always_comb begin
        if (d_c < $signed(33'(SPAN_MIN))) begin
            span_c = SPAN_W'(SPAN_MIN);
        end else if (d_c > $signed(33'(SPAN_MAX))) begin
            span_c = SPAN_W'(SPAN_MAX);
        end else begin
            span_c = d_c[SPAN_W-1:0];
        end
    end

    // Control of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage A captures the decoded item, stage B holds the two products.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_has_last_reg <= s_has_last;
            a_target_reg   <= s_last_target;
            a_bad_reg      <= bad_c;
            a_mant_reg     <= mant_c;
            a_expo_reg     <= expo_c;
            a_span_reg     <= span_c;
            a_y_reg        <= x_c >> INT_SHIFT;
            a_lowzero_reg  <= (x_c & INT_LOWMASK) == 32'd0;

            b_has_last_reg <= a_has_last_reg;
            b_target_reg   <= a_target_reg;
            b_bad_reg      <= a_bad_reg;
            b_expo_reg     <= a_expo_reg;
            b_prod_reg     <= PROD_W'(a_mant_reg) * PROD_W'(a_span_reg);
            b_mod_reg      <= a_y_reg * INT_INV;
            b_lowzero_reg  <= a_lowzero_reg;
        end
    end

    // Classification of the item for the back end.
    assign boundary_c = b_lowzero_reg && (b_mod_reg <= INT_LIM);
    always_comb begin
        push_item.word = b_target_reg;
        push_item.prod = b_prod_reg;
        push_item.expo = b_expo_reg;
        if (!b_has_last_reg) begin
            push_item.mode       = MODE_LIMIT;
            push_item.retargeted = 1'b0;
            push_item.bad        = 1'b0;
        end else if (!boundary_c) begin
            push_item.mode       = MODE_PASS;
            push_item.retargeted = 1'b0;
            push_item.bad        = 1'b0;
        end else if (b_bad_reg) begin
            push_item.mode       = MODE_LIMIT;
            push_item.retargeted = 1'b1;
            push_item.bad        = 1'b1;
        end else begin
            push_item.mode       = MODE_CALC;
            push_item.retargeted = 1'b1;
            push_item.bad        = 1'b0;
        end
    end

endmodule

// File: rtl/pdr_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified items between the front and the back end.
module pdr_queue import pdr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  pdr_item_t  push_item,
    input  logic       pop,
    output pdr_item_t  head_item,
    output pdr_qstat_t q_stat
);

    pdr_item_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;
    assign head_item    = entry_reg[rd_ptr_reg];

    // Occupancy follows the transfers on both sides.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/pdr_back.sv
`timescale 1ns / 1ps
// Back end: scales the target by the span, caps at the limit and encodes.
module pdr_back import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pdr_qstat_t  q_stat,
    input  pdr_item_t   head_item,
    output logic        pop,
    input  logic [31:0] limit_compact,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_target,
    output logic        m_retargeted,
    output logic        m_bad_target
);

    logic                en;
    pdr_bpay_t           head_pay;

    // Divider stage inputs and combinational results.
    logic [NDIG-1:0]     a_v_in;
    logic [REM_W-1:0]    a_r_in   [NDIG];
    logic [Q_W-1:0]      a_q_in   [NDIG];
    logic [NUMP_W-1:0]   a_num_in [NDIG];
    pdr_bpay_t           a_pay_in [NDIG];
    logic [T_W-1:0]      a_t_c    [NDIG];
    logic [MULT_W-1:0]   a_p_c    [NDIG];
    logic [DIG_W-1:0]    b_q_c    [NDIG];
    logic [REM_W-1:0]    b_r_c    [NDIG];

    // Divider pipeline registers: A holds the reciprocal product, B the digit.
    logic [NDIG-1:0]     va_reg;
    logic [NDIG-1:0]     vb_reg;
    logic [T_W-1:0]      ta_reg   [NDIG];
    logic [MULT_W-1:0]   pa_reg   [NDIG];
    logic [Q_W-1:0]      qa_reg   [NDIG];
    logic [Q_W-1:0]      qb_reg   [NDIG];
    logic [REM_W-1:0]    rb_reg   [NDIG];
    logic [NUMP_W-1:0]   numa_reg [NDIG];
    logic [NUMP_W-1:0]   numb_reg [NDIG];
    pdr_bpay_t           paya_reg [NDIG];
    pdr_bpay_t           payb_reg [NDIG];

    // Normalize and output stages.
    logic [Q_W-1:0]      n_x_c;
    logic [LEN_W-1:0]    n_b_c;
    logic                vn_reg;
    pdr_num_t            n_num_reg;
    pdr_num_t            n_lim_reg;
    pdr_bpay_t           n_pay_reg;
    logic [31:0]         o_word_c;
    logic                vo_reg;
    logic [31:0]         o_target_reg;
    logic                o_ret_reg;
    logic                o_bad_reg;

    // The whole back end moves unless a finished result waits for its transfer.
    assign en  = !vo_reg || m_ready;
    assign pop = !q_stat.empty && en;

    assign head_pay.mode       = head_item.mode;
    assign head_pay.retargeted = head_item.retargeted;
    assign head_pay.bad        = head_item.bad;
    assign head_pay.word       = head_item.word;
    assign head_pay.expo       = head_item.expo;

    // One 16-bit quotient digit per step of the long division by the odd part.
    for (genvar j = 0; j < NDIG; j++) begin : g_step
        if (j == 0) begin : g_first
            assign a_v_in[j]   = pop;
            assign a_r_in[j]   = '0;
            assign a_q_in[j]   = '0;
            assign a_num_in[j] = NUMP_W'({head_item.prod, {PRESHIFT{1'b0}}});
            assign a_pay_in[j] = head_pay;
        end else begin : g_next
            assign a_v_in[j]   = vb_reg[j-1];
            assign a_r_in[j]   = rb_reg[j-1];
            assign a_q_in[j]   = qb_reg[j-1];
            assign a_num_in[j] = numb_reg[j-1];
            assign a_pay_in[j] = payb_reg[j-1];
        end
        assign a_t_c[j] = {a_r_in[j], a_num_in[j][DIG_W*(NDIG-1-j) +: DIG_W]};
        assign a_p_c[j] = MULT_W'(a_t_c[j]) * MULT_W'(DIV_RECIP);
        assign b_q_c[j] = pa_reg[j][DIV_K +: DIG_W];
        assign b_r_c[j] = REM_W'(ta_reg[j] - T_W'(b_q_c[j] * TS_ODD));
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
            vb_reg <= '0;
            vn_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            va_reg <= a_v_in;
            vb_reg <= va_reg;
            vn_reg <= vb_reg[NDIG-1];
            vo_reg <= vn_reg;
        end
    end

    // Divider data path.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NDIG; j++) begin
                ta_reg[j]   <= a_t_c[j];
                pa_reg[j]   <= a_p_c[j];
                qa_reg[j]   <= a_q_in[j];
                numa_reg[j] <= a_num_in[j];
                paya_reg[j] <= a_pay_in[j];
                rb_reg[j]   <= b_r_c[j];
                qb_reg[j]   <= {qa_reg[j][Q_W-DIG_W-1:0], b_q_c[j]};
                numb_reg[j] <= numa_reg[j];
                payb_reg[j] <= paya_reg[j];
            end
        end
    end

    // The quotient carries three extra bytes of fraction; fold in the exponent.
    always_comb begin
        if (payb_reg[NDIG-1].expo < 8'd3) begin
            n_x_c = qb_reg[NDIG-1] >> (8 * (3 - int'(payb_reg[NDIG-1].expo)));
            n_b_c = '0;
        end else begin
            n_x_c = qb_reg[NDIG-1];
            n_b_c = LEN_W'(payb_reg[NDIG-1].expo - 8'd3);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_num_reg <= norm_num(n_x_c, n_b_c);
            n_lim_reg <= limit_num(limit_compact);
            n_pay_reg <= payb_reg[NDIG-1];
        end
    end

    // Cap at the limit and pick the answer for the item's class.
    always_comb begin
        case (n_pay_reg.mode)
            MODE_PASS:  o_word_c = n_pay_reg.word;
            MODE_LIMIT: o_word_c = encode_num(n_lim_reg);
            MODE_CALC:  o_word_c = encode_num(num_gt(n_num_reg, n_lim_reg) ? n_lim_reg
                                                                          : n_num_reg);
            default:    o_word_c = n_pay_reg.word;
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            o_target_reg <= o_word_c;
            o_ret_reg    <= n_pay_reg.retargeted;
            o_bad_reg    <= n_pay_reg.bad;
        end
    end

    assign m_valid       = vo_reg;
    assign m_next_target = o_target_reg;
    assign m_retargeted  = o_ret_reg;
    assign m_bad_target  = o_bad_reg;

endmodule

// File: rtl/pow_difficulty_retarget.sv
// An item passes front stages A and B, the queue, the divider, then normalize and output.
// Throughput: one item per cycle; front and back each hold a stage-wide stall,
// and a four-entry queue between them absorbs back-pressure from the result side.
// The division by the timespan takes two stages per 16-bit digit, four digits.
// Reset is synchronous and active low: it empties all stages and the queue and
// sets the limit register to 0x1D00FFFF.
`timescale 1ns / 1ps
`include "pow_difficulty_retarget_macros.svh"
module pow_difficulty_retarget import pdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_last,
    input  logic [30:0] s_last_height,
    input  logic [31:0] s_last_target,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_window_start_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_target,
    output logic        m_retargeted,
    output logic        m_bad_target
);

    logic [31:0] limit_reg;
    logic        push;
    logic        pop;
    pdr_item_t   push_item;
    pdr_item_t   head_item;
    pdr_qstat_t  q_stat;

    // Limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    pdr_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_has_last          (s_has_last),
        .s_last_height       (s_last_height),
        .s_last_target       (s_last_target),
        .s_last_time         (s_last_time),
        .s_window_start_time (s_window_start_time),
        .q_stat              (q_stat),
        .push                (push),
        .push_item           (push_item)
    );

    pdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    pdr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .head_item     (head_item),
        .pop           (pop),
        .limit_compact (limit_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_target (m_next_target),
        .m_retargeted  (m_retargeted),
        .m_bad_target  (m_bad_target)
    );

    // Checks on the block's own control.
    `PDR_ASSERT_ALWAYS(a_out_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `PDR_ASSERT(a_ready_full, aclk, aresetn, !s_ready |-> q_stat.full, "front stalled with room")
    `PDR_ASSERT(a_q_count, aclk, aresetn, q_stat.count <= QCNT_W'(QDEPTH), "queue overflow")
    `PDR_ASSERT(a_bad_flag, aclk, aresetn, m_valid && m_bad_target |-> m_retargeted, "bad flag alone")

endmodule

// File: tb/pdr_retarget_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the next compact target for every input transfer and compares results.
module pdr_retarget_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_has_last,
    input  logic [30:0] s_last_height,
    input  logic [31:0] s_last_target,
    input  logic [31:0] s_last_time,
    input  logic [31:0] s_window_start_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_next_target,
    input  logic        m_retargeted,
    input  logic        m_bad_target,
    output int          fail_count,
    output int          pending
);
    import pdr_pkg::*;

    typedef logic [319:0] wide_t;

    typedef struct {
        logic [31:0] next_target;
        logic        retargeted;
        logic        bad_target;
    } retarget_t;

    retarget_t   targets_due[$];
    logic [31:0] limit_word;

    assign pending = targets_due.size();

    // Number of significant bits in a wide value.
    function automatic int wide_bitlen(input wide_t v);
        int n;
        n = 0;
        for (int i = 0; i < 320; i++) begin
            if (v[i]) n = i + 1;
        end
        return n;
    endfunction

    // Expand a mantissa and byte length into a full value.
    function automatic wide_t expand_compact(input logic [22:0] m, input int sz);
        wide_t v;
        v = '0;
        v[22:0] = m;
        if (sz <= 3) return v >> (8 * (3 - sz));
        return v << (8 * (sz - 3));
    endfunction

    // Shortest standard compact form of a value.
    function automatic logic [31:0] to_compact(input wide_t v);
        int          sz;
        logic [31:0] c;
        wide_t       sh;
        sz = (wide_bitlen(v) + 7) / 8;
        if (sz <= 3) begin
            c = v[31:0] << (8 * (3 - sz));
        end else begin
            sh = v >> (8 * (sz - 3));
            c = {8'd0, sh[23:0]};
        end
        if (c[23]) begin
            c = c >> 8;
            sz++;
        end
        return {8'(sz), c[23:0]};
    endfunction

    // Work out the result that one input item must produce.
    function automatic retarget_t next_difficulty(input logic has, input logic [30:0] h,
                                                  input logic [31:0] t, input logic [31:0] tl,
                                                  input logic [31:0] tw, input logic [31:0] lim);
        retarget_t    r;
        wide_t        cap, v;
        logic [22:0]  m;
        int           sz, mbits;
        longint       span;
        cap = expand_compact(lim[22:0], int'(lim[31:24]));
        cap = cap & ((wide_t'(1) << 256) - wide_t'(1));
        r.retargeted = 1'b0;
        r.bad_target = 1'b0;
        if (!has) begin
            r.next_target = to_compact(cap);
            return r;
        end
        if (((longint'(h) + 1) % 2016) != 0) begin
            r.next_target = t;
            return r;
        end
        r.retargeted = 1'b1;
        m = t[22:0];
        sz = int'(t[31:24]);
        mbits = 0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) mbits = i + 1;
        end
        if (m != 0 && (t[23] || (sz > 3 && mbits + 8 * (sz - 3) > 256))) begin
            r.next_target = to_compact(cap);
            r.bad_target = 1'b1;
            return r;
        end
        span = longint'(tl) - longint'(tw);
        if (span < 302400) span = 302400;
        if (span > 4838400) span = 4838400;
        v = expand_compact(m, sz);
        v = (v * wide_t'(span)) / wide_t'(1209600);
        if (v > cap) v = cap;
        r.next_target = to_compact(v);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        limit_word = LIMIT_RESET;
    end

    // Track the register, predict on input transfers and compare on result transfers.
    always @(posedge aclk) begin
        retarget_t want;
        if (!aresetn) begin
            limit_word <= LIMIT_RESET;
        end else begin
            if (cfg_we) limit_word <= cfg_wdata;
            if (s_valid && s_ready) begin
                targets_due.push_back(next_difficulty(s_has_last, s_last_height,
                    s_last_target, s_last_time, s_window_start_time, limit_word));
            end
            if (m_valid && m_ready) begin
                if (targets_due.size() == 0) begin
                    report_mismatch("unexpected result", m_next_target, 32'd0);
                end else begin
                    want = targets_due.pop_front();
                    if (m_next_target !== want.next_target)
                        report_mismatch("next_target", m_next_target, want.next_target);
                    if (m_retargeted !== want.retargeted)
                        report_mismatch("retargeted", 32'(m_retargeted), 32'(want.retargeted));
                    if (m_bad_target !== want.bad_target)
                        report_mismatch("bad_target", 32'(m_bad_target), 32'(want.bad_target));
                end
            end
        end
    end
endmodule

// File: tb/tb_pow_difficulty_retarget.sv
`timescale 1ns / 1ps
// Top of the difficulty retarget testbench: clock, reset, stimulus and verdict.
module tb_pow_difficulty_retarget;
    import pdr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_has_last = 1'b0;
    logic [30:0] s_last_height = '0;
    logic [31:0] s_last_target = '0;
    logic [31:0] s_last_time = '0;
    logic [31:0] s_window_start_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_next_target;
    logic        m_retargeted;
    logic        m_bad_target;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count = 0;

    always #5 aclk = ~aclk;

    pow_difficulty_retarget uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_has_last(s_has_last),
        .s_last_height(s_last_height), .s_last_target(s_last_target),
        .s_last_time(s_last_time), .s_window_start_time(s_window_start_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_next_target(m_next_target),
        .m_retargeted(m_retargeted), .m_bad_target(m_bad_target)
    );

    pdr_retarget_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_has_last(s_has_last),
        .s_last_height(s_last_height), .s_last_target(s_last_target),
        .s_last_time(s_last_time), .s_window_start_time(s_window_start_time),
        .m_valid(m_valid), .m_ready(m_ready), .m_next_target(m_next_target),
        .m_retargeted(m_retargeted), .m_bad_target(m_bad_target),
        .fail_count(fail_count), .pending(pending)
    );

    // Random back-pressure on the result side.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Run watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb_pow_difficulty_retarget failed");
            $finish;
        end
    end

    // Present one block description and hold it until the transfer happens.
    task automatic send_block(input logic has, input logic [30:0] h, input logic [31:0] t,
                              input logic [31:0] tl, input logic [31:0] tw);
        s_has_last <= has;
        s_last_height <= h;
        s_last_target <= t;
        s_last_time <= tl;
        s_window_start_time <= tw;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Let the pipeline drain, then write the limit register.
    task automatic write_limit(input logic [31:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Random block, mostly on retarget boundaries with plausible targets and times.
    task automatic send_random_block();
        logic [30:0] h;
        logic [31:0] t, tl, tw;
        h = 31'($urandom);
        if ($urandom_range(99) < 60) h = 31'($urandom_range(1065220, 1) * 2016 - 1);
        t = $urandom;
        if ($urandom_range(99) < 70)
            t = {8'($urandom_range(33, 0)), 1'b0, 23'($urandom)};
        tl = $urandom;
        case ($urandom_range(3))
            0: tw = $urandom;
            1: tw = tl - $urandom_range(302400, 0);
            2: tw = tl - $urandom_range(4838400, 302400);
            default: tw = tl - $urandom_range(9000000, 4838400);
        endcase
        send_block($urandom_range(99) < 92, h, t, tl, tw);
    endtask

    initial begin
        logic [31:0] limits [5];
        limits = '{32'hFFFFFFFF, 32'h00000000, 32'h207FFFFF, 32'h03123456, 32'h1B0404CB};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset limit.
        send_block(1'b0, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_block(1'b1, 31'd5, 32'h12345678, 32'd0, 32'd0);
        send_block(1'b1, 31'h7FFFFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF);
        send_block(1'b1, 31'd2015, 32'h1D00FFFF, 32'd1209600, 32'd0);
        send_block(1'b1, 31'd2015, 32'h1B0404CB, 32'd100, 32'd200);
        send_block(1'b1, 31'd4031, 32'h1B0404CB, 32'hFFFFFFFF, 32'd0);
        send_block(1'b1, 31'd4031, 32'h00000000, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'h04800000, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'h1D80FFFF, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'h217FFFFF, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'h21007FFF, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'hFF000001, 32'd5000000, 32'd0);
        send_block(1'b1, 31'd4031, 32'h03123456, 32'd4838400, 32'd0);
        send_block(1'b1, 31'd4031, 32'h01120000, 32'd302400, 32'd0);
        send_block(1'b1, 31'd4031, 32'h1C7FFFFF, 32'd2419200, 32'd0);
        send_block(1'b1, 31'd4031, 32'h1A000001, 32'd302401, 32'd0);
        send_block(1'b1, 31'd4031, 32'h10000003, 32'd400000, 32'd0);

        // Random phases: receiver idles most, then sender idles most, then neither.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 70 : 0;
            recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 26 : 0;
            if (ph > 0) write_limit(limits[ph - 1]);
            for (int i = 0; i < 155; i++) begin
                if (ph == 2 && i == 77) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
                send_random_block();
                if (i % 40 == 39) send_block(1'b0, 31'($urandom), $urandom, $urandom, $urandom);
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_pow_difficulty_retarget passed");
        end else begin
            $display("tb_pow_difficulty_retarget failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/pdr_pkg.sv
rtl/pdr_front.sv
rtl/pdr_queue.sv
rtl/pdr_back.sv
rtl/pow_difficulty_retarget.sv
tb/pdr_retarget_checker.sv
tb/tb_pow_difficulty_retarget.sv
